@@ hw/rtl/grid_mask_triangulation_core_assert.svh @@
// Assertion macros shared by the grid mask triangulation RTL.
// Each expects i_clk and i_rst_n in scope; checks are off while reset is held.
`ifndef GRID_MASK_TRIANGULATION_CORE_ASSERT_SVH
`define GRID_MASK_TRIANGULATION_CORE_ASSERT_SVH

// Same-cycle implication.
`define GMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GMT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gmt_pkg.sv @@
`timescale 1ns / 1ps
package gmt_pkg;

    // Frame geometry limits
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
    localparam int unsigned W_W        = COL_W + 1;
    localparam int unsigned H_W        = ROW_W + 1;

    // Fixed field widths
    localparam int unsigned DIM_W      = 11;
    localparam int unsigned IDX_W      = 20;
    localparam int unsigned CFG_IDX_W  = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd1;

    // Register reset values
    localparam int unsigned RESET_WIDTH  = 640;
    localparam int unsigned RESET_HEIGHT = 480;

    // Occupancy codes that produce triangles
    localparam logic [3:0] CODE_7  = 4'd7;
    localparam logic [3:0] CODE_11 = 4'd11;
    localparam logic [3:0] CODE_13 = 4'd13;
    localparam logic [3:0] CODE_14 = 4'd14;
    localparam logic [3:0] CODE_15 = 4'd15;

    // Quad queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified quad: its code and the index of its bottom-right corner
    typedef struct packed {
        logic [3:0]       code;
        logic [IDX_W-1:0] p3;
    } t_quad;

    // Clamp a register value into 2..hi
    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v,
                                              input int unsigned hi);
        int unsigned x;
        x = int'(v);
        if (x < 2) begin
            return 2;
        end
        if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

    // True for the codes that produce at least one triangle
    function automatic logic code_emits(input logic [3:0] code);
        return (code == CODE_7) || (code == CODE_11) || (code == CODE_13) ||
               (code == CODE_14) || (code == CODE_15);
    endfunction

endpackage

@@ hw/rtl/grid_mask_triangulation_core.sv @@
// Throughput: 1 pixel per cycle in unless the queue is full, 1 triangle per cycle out while
// i_tri_ready is high; a fully set quad gives two triangles, and a 4-entry quad queue between
// classifier and emitter takes up those bursts. Reset (i_rst_n low at a clock edge) clears the
// raster counters, the pipeline and the queue, and sets row_width to 640 and row_count to 480;
// the line buffer is not cleared.
`timescale 1ns / 1ps
module grid_mask_triangulation_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gmt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gmt_pkg::DIM_W-1:0]        i_cfg_data,
    input  logic                             i_pix_valid,
    output logic                             o_pix_ready,
    input  logic                             i_pixel_label,
    input  logic                             i_frame_start,
    output logic                             o_tri_valid,
    input  logic                             i_tri_ready,
    output logic [gmt_pkg::IDX_W-1:0]        o_vertex_first,
    output logic [gmt_pkg::IDX_W-1:0]        o_vertex_second,
    output logic [gmt_pkg::IDX_W-1:0]        o_vertex_third,
    output logic                             o_last_of_run
);
    import gmt_pkg::*;

    // Frame size, held already clamped
    logic [W_W-1:0] r_w;
    logic [H_W-1:0] r_h;

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_quad w_quad_in;
    t_quad w_quad_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= W_W'(clamp_dim(DIM_W'(RESET_WIDTH), MAX_WIDTH));
            r_h <= H_W'(clamp_dim(DIM_W'(RESET_HEIGHT), MAX_HEIGHT));
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_WIDTH: r_w <= W_W'(clamp_dim(i_cfg_data, MAX_WIDTH));
                REG_ROW_COUNT: r_h <= H_W'(clamp_dim(i_cfg_data, MAX_HEIGHT));
                default: begin
                end
            endcase
        end
    end

    gmt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (i_pix_valid),
        .o_pix_ready   (o_pix_ready),
        .i_pixel_label (i_pixel_label),
        .i_frame_start (i_frame_start),
        .i_w           (r_w),
        .i_h           (r_h),
        .o_push        (w_push),
        .o_quad        (w_quad_in),
        .i_full        (w_full)
    );

    gmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_quad  (w_quad_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_quad  (w_quad_out),
        .o_empty (w_empty)
    );

    gmt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_w             (r_w),
        .i_quad          (w_quad_out),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_tri_valid     (o_tri_valid),
        .i_tri_ready     (i_tri_ready),
        .o_vertex_first  (o_vertex_first),
        .o_vertex_second (o_vertex_second),
        .o_vertex_third  (o_vertex_third),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

@@ hw/rtl/gmt_front.sv @@
`timescale 1ns / 1ps
module gmt_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_pix_valid,
    output logic                      o_pix_ready,
    input  logic                      i_pixel_label,
    input  logic                      i_frame_start,
    input  logic [gmt_pkg::W_W-1:0]   i_w,
    input  logic [gmt_pkg::H_W-1:0]   i_h,
    output logic                      o_push,
    output gmt_pkg::t_quad            o_quad,
    input  logic                      i_full
);
    import gmt_pkg::*;

    // Line buffer holding the previous row's labels
    logic r_line [MAX_WIDTH];
    logic r_above;

    // Raster position
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_base, n_base;

    // Classification stage
    logic             r_b_valid;
    logic             r_b_label;
    logic             r_b_ok;
    logic [IDX_W-1:0] r_b_p3;
    logic             r_left_cur;
    logic             r_left_prev;

    logic             w_accept;
    logic             w_b_go;
    logic             w_emit;
    logic [3:0]       w_code;
    logic [COL_W-1:0] w_col;
    logic [ROW_W-1:0] w_row;
    logic [IDX_W-1:0] w_base;
    logic [W_W-1:0]   w_col_inc;
    logic [H_W-1:0]   w_row_inc;

    // Quad code: bit0 top-left, bit1 top-right, bit2 bottom-left, bit3 bottom-right
    assign w_code = {r_b_label, r_left_cur, r_above, r_left_prev};
    assign w_emit = r_b_ok && code_emits(w_code);
    assign w_b_go = !w_emit || !i_full;

    assign o_pix_ready = !r_b_valid || w_b_go;
    assign w_accept    = i_pix_valid && o_pix_ready;

    assign o_push      = r_b_valid && w_emit && !i_full;
    assign o_quad.code = w_code;
    assign o_quad.p3   = r_b_p3;

    // Frame start forces the pixel to column 0, row 0
    assign w_col     = i_frame_start ? '0 : r_col;
    assign w_row     = i_frame_start ? '0 : r_row;
    assign w_base    = i_frame_start ? '0 : r_base;
    assign w_col_inc = {1'b0, w_col} + W_W'(1);
    assign w_row_inc = {1'b0, w_row} + H_W'(1);

    // Next raster position
    always_comb begin
        n_col  = w_col_inc[COL_W-1:0];
        n_row  = w_row;
        n_base = w_base;
        if (w_col_inc >= i_w) begin
            n_col = '0;
            if (w_row_inc >= i_h) begin
                n_row  = '0;
                n_base = '0;
            end else begin
                n_row  = w_row_inc[ROW_W-1:0];
                n_base = w_base + IDX_W'(i_w);
            end
        end
    end

    // Counters and classification state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_base      <= '0;
            r_b_valid   <= 1'b0;
            r_left_cur  <= 1'b0;
            r_left_prev <= 1'b0;
        end else begin
            if (r_b_valid && w_b_go) begin
                r_left_prev <= r_above;
                r_left_cur  <= r_b_label;
            end
            if (w_accept) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_base    <= n_base;
                r_b_valid <= 1'b1;
            end else if (w_b_go) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Payload of the classification stage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_label <= i_pixel_label;
            r_b_ok    <= (w_col != '0) && (w_row != '0);
            r_b_p3    <= w_base + IDX_W'(w_col);
        end
    end

    // Line buffer: read the label above, then store this pixel in its place
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_above      <= r_line[w_col];
            r_line[w_col] <= i_pixel_label;
        end
    end

endmodule

@@ hw/rtl/gmt_queue.sv @@
`timescale 1ns / 1ps
`include "grid_mask_triangulation_core_assert.svh"
module gmt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gmt_pkg::t_quad i_quad,
    output logic           o_full,
    input  logic           i_pop,
    output gmt_pkg::t_quad o_quad,
    output logic           o_empty
);
    import gmt_pkg::*;

    t_quad             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_quad  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_quad;
        end
    end

    `GMT_ASSERT_IMP(a_no_push_full, i_push, !o_full, "quad pushed into a full queue")
    `GMT_ASSERT_IMP(a_no_pop_empty, i_pop, !o_empty, "quad popped from an empty queue")
    `GMT_ASSERT_IMP(a_count_range, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")

endmodule

@@ hw/rtl/gmt_back.sv @@
`timescale 1ns / 1ps
`include "grid_mask_triangulation_core_assert.svh"
module gmt_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gmt_pkg::W_W-1:0]    i_w,
    input  gmt_pkg::t_quad             i_quad,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_tri_valid,
    input  logic                       i_tri_ready,
    output logic [gmt_pkg::IDX_W-1:0]  o_vertex_first,
    output logic [gmt_pkg::IDX_W-1:0]  o_vertex_second,
    output logic [gmt_pkg::IDX_W-1:0]  o_vertex_third,
    output logic                       o_last_of_run
);
    import gmt_pkg::*;

    logic             r_valid;
    logic             r_second;
    logic [IDX_W-1:0] r_v0, r_v1, r_v2;
    logic             r_last;

    logic             w_load;
    logic             w_split;
    logic [IDX_W-1:0] w_p0, w_p1, w_p2, w_p3, w_wx;
    logic [IDX_W-1:0] n_v0, n_v1, n_v2;
    logic             n_last;

    assign w_load  = (!r_valid || i_tri_ready) && !i_empty;
    assign w_split = (i_quad.code == CODE_15) && !r_second;
    assign o_pop   = w_load && !w_split;

    // Corner indices of the quad
    assign w_wx = IDX_W'(i_w);
    assign w_p3 = i_quad.p3;
    assign w_p2 = w_p3 - IDX_W'(1);
    assign w_p1 = w_p3 - w_wx;
    assign w_p0 = w_p3 + ~w_wx;

    // Triangle selection, counter-clockwise
    always_comb begin
        n_v0   = w_p0;
        n_v1   = w_p2;
        n_v2   = w_p1;
        n_last = 1'b1;
        case (i_quad.code)
            CODE_11: begin
                n_v1 = w_p3;
            end
            CODE_13: begin
                n_v2 = w_p3;
            end
            CODE_14: begin
                n_v0 = w_p1;
                n_v2 = w_p3;
            end
            CODE_15: begin
                if (r_second) begin
                    n_v0 = w_p3;
                    n_v1 = w_p1;
                    n_v2 = w_p2;
                end else begin
                    n_last = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register and split tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid  <= 1'b1;
                r_second <= w_split;
            end else if (i_tri_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_v0   <= n_v0;
            r_v1   <= n_v1;
            r_v2   <= n_v2;
            r_last <= n_last;
        end
    end

    assign o_tri_valid     = r_valid;
    assign o_vertex_first  = r_v0;
    assign o_vertex_second = r_v1;
    assign o_vertex_third  = r_v2;
    assign o_last_of_run   = r_last;

    `GMT_ASSERT_NXT(a_split_follows, r_valid && i_tri_ready && !r_last, r_valid && r_last,
        "second triangle of a full quad did not follow")
    `GMT_ASSERT_IMP(a_split_held, r_second, !i_empty, "full quad left the queue before its second half")

endmodule

@@ dv/tb_grid_mask_triangulation_core.sv @@
`timescale 1ns / 1ps
module tb_grid_mask_triangulation_core;
    import gmt_pkg::*;

    // One triangle as it leaves the block
    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
        logic [IDX_W-1:0] third;
        logic             last;
    } triangle_t;

    // Directed stimulus row; typed rows carry their own expected triangles
    typedef struct packed {
        logic       label;
        logic       fs;
        logic       typed;
        logic [1:0] n;
        triangle_t  t0;
        triangle_t  t1;
    } pixel_row_t;

    localparam triangle_t NO_TRI = '0;
    localparam int unsigned NUM_DIR = 26;
    localparam int unsigned NUM_PHASES = 10;

    // Random phases: register values, pixel count, label density (%), frame start (per mille)
    int unsigned ph_width [NUM_PHASES] = '{5, 2, 0, 7, 4, 16, 2047, 1024, 1024, 3};
    int unsigned ph_height[NUM_PHASES] = '{4, 1024, 0, 2047, 3, 5, 2, 2, 1024, 2};
    int unsigned ph_items [NUM_PHASES] = '{150, 130, 60, 110, 90, 130, 40, 40, 40, 130};
    int unsigned ph_ones  [NUM_PHASES] = '{80, 85, 90, 60, 75, 70, 92, 50, 60, 50};
    int unsigned ph_fs    [NUM_PHASES] = '{15, 5, 20, 10, 15, 10, 0, 0, 0, 20};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_ROW_WIDTH;
    logic [DIM_W-1:0]      i_cfg_data = '0;
    logic                  i_pix_valid = 1'b0;
    logic                  o_pix_ready;
    logic                  i_pixel_label = 1'b0;
    logic                  i_frame_start = 1'b0;
    logic                  o_tri_valid;
    logic                  i_tri_ready = 1'b0;
    logic [IDX_W-1:0]      o_vertex_first;
    logic [IDX_W-1:0]      o_vertex_second;
    logic [IDX_W-1:0]      o_vertex_third;
    logic                  o_last_of_run;

    grid_mask_triangulation_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pix_valid     (i_pix_valid),
        .o_pix_ready     (o_pix_ready),
        .i_pixel_label   (i_pixel_label),
        .i_frame_start   (i_frame_start),
        .o_tri_valid     (o_tri_valid),
        .i_tri_ready     (i_tri_ready),
        .o_vertex_first  (o_vertex_first),
        .o_vertex_second (o_vertex_second),
        .o_vertex_third  (o_vertex_third),
        .o_last_of_run   (o_last_of_run)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    int unsigned errors = 0;
    bit          steady = 1'b0;
    triangle_t   pending_tris[$];
    triangle_t   got_tri;
    triangle_t   want_tri;
    pixel_row_t  dir_rows [NUM_DIR];

    // Raster state mirrored from the block
    logic [DIM_W-1:0] width_reg = DIM_W'(RESET_WIDTH);
    logic [DIM_W-1:0] height_reg = DIM_W'(RESET_HEIGHT);
    bit               line_labels [MAX_WIDTH];
    bit               line_seen   [MAX_WIDTH];
    int unsigned      col_cnt = 0;
    int unsigned      row_cnt = 0;
    bit               left_cur = 1'b0;
    bit               left_up = 1'b0;
    logic [IDX_W-1:0] row_base = '0;

    function automatic triangle_t make_tri(input logic [IDX_W-1:0] a, b, c, input logic last);
        triangle_t t;
        t.first = a;
        t.second = b;
        t.third = c;
        t.last = last;
        return t;
    endfunction

    function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v < 2) begin
            return 2;
        end
        if (v > hi) begin
            return hi;
        end
        return int'(v);
    endfunction

    // Advance the raster state by one pixel; queue the triangles it closes when asked
    function automatic void triangulate_pixel(input logic label, input logic fs,
                                              input bit queue_it);
        int unsigned      w;
        int unsigned      h;
        int unsigned      u;
        logic             above;
        logic [3:0]       code;
        logic [IDX_W-1:0] p0, p1, p2, p3;
        w = dim_in_use(width_reg, MAX_WIDTH);
        h = dim_in_use(height_reg, MAX_HEIGHT);
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
            row_base = '0;
        end
        u = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
        above = line_labels[u];
        if (queue_it && u >= 1 && row_cnt >= 1) begin
            p3 = row_base + IDX_W'(u);
            p2 = p3 - 1'b1;
            p1 = p3 - IDX_W'(w);
            p0 = p1 - 1'b1;
            code = {label, left_cur, above, left_up};
            case (code)
                CODE_7:  pending_tris.push_back(make_tri(p0, p2, p1, 1'b1));
                CODE_11: pending_tris.push_back(make_tri(p0, p3, p1, 1'b1));
                CODE_13: pending_tris.push_back(make_tri(p0, p2, p3, 1'b1));
                CODE_14: pending_tris.push_back(make_tri(p1, p2, p3, 1'b1));
                CODE_15: begin
                    pending_tris.push_back(make_tri(p0, p2, p1, 1'b0));
                    pending_tris.push_back(make_tri(p3, p1, p2, 1'b1));
                end
                default: ;
            endcase
        end
        left_up = above;
        line_labels[u] = label;
        line_seen[u] = 1'b1;
        left_cur = label;
        // Row wrap, then frame wrap
        if (u + 1 >= w) begin
            col_cnt = 0;
            row_cnt++;
            row_base = row_base + IDX_W'(w);
            if (row_cnt >= h) begin
                row_cnt = 0;
                row_base = '0;
            end
        end else begin
            col_cnt = u + 1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [IDX_W-1:0] want, got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Present one pixel and hold it until the transfer
    task automatic send_pixel(input logic label, input logic fs);
        if (!steady && $urandom_range(99) < 18) begin
            i_pix_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 18);
        end
        i_pix_valid <= 1'b1;
        i_pixel_label <= label;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_pix_ready);
    endtask

    // Both registers, back to back; only called while the block is idle
    task automatic write_regs(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_ROW_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_index <= REG_ROW_COUNT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    // Stop sending, wait for every queued triangle, then cover the pipeline latency
    task automatic drain_results();
        i_pix_valid <= 1'b0;
        while (pending_tris.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Triangle sink: compare each transfer, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_tri_valid && i_tri_ready) begin
            got_tri = make_tri(o_vertex_first, o_vertex_second, o_vertex_third, o_last_of_run);
            if (pending_tris.size() == 0) begin
                errors++;
                $display("%0t: unexpected triangle, expected none, got %0d %0d %0d last %0d",
                         $time, got_tri.first, got_tri.second, got_tri.third, got_tri.last);
            end else begin
                want_tri = pending_tris.pop_front();
                check_field("vertex_first", want_tri.first, got_tri.first);
                check_field("vertex_second", want_tri.second, got_tri.second);
                check_field("vertex_third", want_tri.third, got_tri.third);
                check_field("last_of_run", IDX_W'(want_tri.last), IDX_W'(got_tri.last));
            end
        end
        i_tri_ready <= steady ? 1'b1 : ($urandom_range(99) >= 18);
    end

    // Stimulus
    initial begin
        int unsigned k;
        int unsigned p;
        int unsigned rand_count;
        int unsigned u_next;
        logic        lab;
        logic        fs;
        pixel_row_t  row;

        // 2x2 frames (registers clamped up from 0 and 1): label, frame start, typed, count
        dir_rows = '{
            {1'b1, 1'b1, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd2, make_tri(0, 2, 1, 1'b0), make_tri(3, 1, 2, 1'b1)},
            // frame end wraps with no frame start
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b0, 1'b0, 1'b1, 2'd1, make_tri(0, 2, 1, 1'b1), NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b0, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd1, make_tri(0, 3, 1, 1'b1), NO_TRI},
            {1'b1, 1'b1, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b0, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd1, make_tri(0, 2, 3, 1'b1), NO_TRI},
            {1'b0, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd1, make_tri(1, 2, 3, 1'b1), NO_TRI},
            // frame start in the middle of a frame, then an empty-result quad
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b1, 2'd0, NO_TRI, NO_TRI},
            {1'b0, 1'b1, 1'b0, 2'd0, NO_TRI, NO_TRI},
            {1'b0, 1'b0, 1'b0, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b0, 2'd0, NO_TRI, NO_TRI},
            {1'b1, 1'b0, 1'b0, 2'd0, NO_TRI, NO_TRI}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        write_regs(11'd0, 11'd1);
        for (k = 0; k < NUM_DIR; k++) begin
            row = dir_rows[k];
            send_pixel(row.label, row.fs);
            triangulate_pixel(row.label, row.fs, !row.typed);
            if (row.typed && row.n >= 1) begin
                pending_tris.push_back(row.t0);
            end
            if (row.typed && row.n == 2) begin
                pending_tris.push_back(row.t1);
            end
        end
        drain_results();

        // Random part, one register setting per phase
        rand_count = 0;
        for (p = 0; p < NUM_PHASES; p++) begin
            write_regs(DIM_W'(ph_width[p]), DIM_W'(ph_height[p]));
            for (k = 0; k < ph_items[p]; k++) begin
                steady = (rand_count >= 400 && rand_count < 600);
                lab = ($urandom_range(99) < ph_ones[p]);
                fs = ($urandom_range(999) < ph_fs[p]);
                // a grown width would read line buffer entries never written: restart frame
                u_next = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
                if (!fs && row_cnt >= 1 && !line_seen[u_next]) begin
                    fs = 1'b1;
                end
                send_pixel(lab, fs);
                triangulate_pixel(lab, fs, 1'b1);
                rand_count++;
            end
            drain_results();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit
    initial begin
        #500000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
